[rtl/olt_pkg.sv]
// Shared types and constants for the ordered list table.
// Holds command, status and sequencer codes; no dependencies.
package olt_pkg;

	localparam int CAPACITY_DEF    = 256;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam int CMD_W    = 3;
	localparam int POS_W    = 8;
	localparam int EXT_W    = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND     = 3'd0,
		CMD_INSERT     = 3'd1,
		CMD_REMOVE_AT  = 3'd2,
		CMD_REMOVE_VAL = 3'd3,
		CMD_READ_AT    = 3'd4,
		CMD_INDEX_OF   = 3'd5,
		CMD_CLEAR      = 3'd6
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_RANGE  = 2'd2,
		ST_ABSENT = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT_UP,
		S_PUT,
		S_SHIFT_DN,
		S_SEARCH,
		S_READ
	} state_t;

endpackage

[rtl/olt_mem.sv]
// Entry store for the ordered list table: one write port and one read port.
// Read data is registered, so it appears in the cycle after the address is given.
module olt_mem #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/ordered_list_table.sv]
// Top level of the ordered list table: command sequencer and result register.
// Depends on olt_pkg and instantiates the entry store olt_mem.
//
// The block keeps an ordered list of up to CAPACITY handles in a single
// one-read, one-write memory. A request is taken when start is high while busy
// is low; exactly one result follows, shown for one cycle with done high, and
// it cannot be held off, so it must be captured in that cycle. A new request
// may be given in the very cycle that done is high. The count of entries on
// entry_count is the count after the request. Timing is set by the memory
// walk: one entry is read per cycle and each read in a shift is written back
// one place along in the following cycle. Append, clear, a refused request
// and the unused command give their result straight from idle, as does an
// insert at or past the end, which appends, a remove at the last position,
// and an index of or remove value on an empty list. Read at reads its one
// entry in S_READ. An insert inside the list shifts the entries from the last
// down to the position up one place in S_SHIFT_UP, then writes the value in
// S_PUT. A remove shifts the entries after the position down one place in
// S_SHIFT_DN. Index of and remove value search from the front in S_SEARCH;
// remove value then shifts the entries after the match down, unless the match
// is the last entry. No clearing pass is needed after reset: entries at or
// past the count are never read.
module ordered_list_table
	import olt_pkg::*;
#(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [CMD_W-1:0]    cmd,
	input  logic [POS_W-1:0]    position,
	input  logic [EXT_W-1:0]    entry_value,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [EXT_W-1:0]    read_value,
	output logic [POS_W-1:0]    found_position,
	output logic [COUNT_W-1:0]  entry_count
);

	// Address width of the store, width of the count, and a width wide enough
	// to compare a request position against the count.
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	// Sequencer state and walk registers.
	state_t              state_q, state_d;
	logic [AW-1:0]       ptr_q, ptr_d;
	logic                iss_q, iss_d;
	logic [CW-1:0]       cnt_q, cnt_d;
	logic [AW-1:0]       tgt_q, tgt_d;
	logic [VALUE_WIDTH-1:0] val_q, val_d;
	cmd_t                cmd_q, cmd_d;

	// Stage one holds the address whose read data is arriving from the store.
	logic                vld_s1, vld_d;
	logic [AW-1:0]       addr_s1, addr_d;

	// Result register.
	logic                done_q, done_d;
	status_t             status_q, status_d;
	logic [EXT_W-1:0]    read_q, read_d;
	logic [POS_W-1:0]    found_q, found_d;

	// Memory port signals.
	logic                   mem_we, mem_re;
	logic [AW-1:0]          mem_waddr, mem_raddr;
	logic [VALUE_WIDTH-1:0] mem_wdata, mem_rdata;

	// Width adaptation of the request fields and of the result fields.
	logic [VALUE_WIDTH+EXT_W-1:0] val_ext;
	logic [VALUE_WIDTH-1:0]       val_in;
	logic [VALUE_WIDTH+EXT_W-1:0] rd_ext;
	logic [AW+POS_W-1:0]          addr_ext;
	logic [CW+COUNT_W-1:0]        cnt_ext;
	logic [PW-1:0]                pos_x, cnt_x;
	logic [AW-1:0]                pos_a, cnt_a, last_a;
	logic [CW-1:0]                cnt_m1;
	logic                         full;

	// Only the low VALUE_WIDTH bits of a handle are kept; a narrower stored
	// value is returned zero-extended.
	assign val_ext  = {{VALUE_WIDTH{1'b0}}, entry_value};
	assign val_in   = val_ext[VALUE_WIDTH-1:0];
	assign rd_ext   = {{EXT_W{1'b0}}, mem_rdata};
	assign addr_ext = {{POS_W{1'b0}}, addr_s1};
	assign cnt_ext  = {{COUNT_W{1'b0}}, cnt_q};

	assign pos_x  = PW'(position);
	assign cnt_x  = PW'(cnt_q);
	assign pos_a  = pos_x[AW-1:0];
	assign cnt_a  = cnt_q[AW-1:0];
	assign cnt_m1 = cnt_q - CW'(1);
	assign last_a = cnt_m1[AW-1:0];
	assign full   = (cnt_q == CW'(CAPACITY));

	olt_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (VALUE_WIDTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iss_q   <= 1'b0;
			vld_s1  <= 1'b0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			iss_q   <= iss_d;
			vld_s1  <= vld_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q    <= ptr_d;
		tgt_q    <= tgt_d;
		val_q    <= val_d;
		cmd_q    <= cmd_d;
		addr_s1  <= addr_d;
		status_q <= status_d;
		read_q   <= read_d;
		found_q  <= found_d;
	end

	// Each walk state issues one read per cycle while iss_q is set, and
	// handles the data of the previous read in stage one. Shifting up walks
	// downwards and writes one place higher; shifting down walks upwards and
	// writes one place lower, so a write never meets the read in flight.
	always_comb begin
		state_d   = state_q;
		ptr_d     = ptr_q;
		iss_d     = iss_q;
		cnt_d     = cnt_q;
		tgt_d     = tgt_q;
		val_d     = val_q;
		cmd_d     = cmd_q;
		vld_d     = 1'b0;
		addr_d    = addr_s1;
		done_d    = 1'b0;
		status_d  = ST_OK;
		read_d    = '0;
		found_d   = '0;
		mem_we    = 1'b0;
		mem_waddr = cnt_a;
		mem_wdata = val_q;
		mem_re    = 1'b0;
		mem_raddr = ptr_q;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					val_d = val_in;
					cmd_d = cmd_t'(cmd);
					case (cmd_t'(cmd))
						CMD_APPEND: begin
							done_d = 1'b1;
							if (full) begin
								status_d = ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = cnt_a;
								mem_wdata = val_in;
								cnt_d     = cnt_q + CW'(1);
							end
						end
						CMD_INSERT: begin
							if (full) begin
								done_d   = 1'b1;
								status_d = ST_FULL;
							end else if (pos_x >= cnt_x) begin
								// A position at or past the end appends.
								done_d    = 1'b1;
								mem_we    = 1'b1;
								mem_waddr = cnt_a;
								mem_wdata = val_in;
								cnt_d     = cnt_q + CW'(1);
							end else begin
								tgt_d   = pos_a;
								ptr_d   = last_a;
								iss_d   = 1'b1;
								state_d = S_SHIFT_UP;
							end
						end
						CMD_REMOVE_AT: begin
							if (pos_x >= cnt_x) begin
								done_d   = 1'b1;
								status_d = ST_RANGE;
							end else if (pos_a == last_a) begin
								done_d = 1'b1;
								cnt_d  = cnt_m1;
							end else begin
								ptr_d   = pos_a + AW'(1);
								iss_d   = 1'b1;
								state_d = S_SHIFT_DN;
							end
						end
						CMD_REMOVE_VAL, CMD_INDEX_OF: begin
							if (cnt_q == '0) begin
								done_d   = 1'b1;
								status_d = ST_ABSENT;
							end else begin
								ptr_d   = '0;
								iss_d   = 1'b1;
								state_d = S_SEARCH;
							end
						end
						CMD_READ_AT: begin
							if (pos_x >= cnt_x) begin
								done_d   = 1'b1;
								status_d = ST_RANGE;
							end else begin
								ptr_d   = pos_a;
								iss_d   = 1'b1;
								state_d = S_READ;
							end
						end
						CMD_CLEAR: begin
							done_d = 1'b1;
							cnt_d  = '0;
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end

			S_SHIFT_UP: begin
				if (iss_q) begin
					mem_re = 1'b1;
					vld_d  = 1'b1;
					addr_d = ptr_q;
					if (ptr_q == tgt_q) begin
						iss_d = 1'b0;
					end else begin
						ptr_d = ptr_q - AW'(1);
					end
				end
				if (vld_s1) begin
					mem_we    = 1'b1;
					mem_waddr = addr_s1 + AW'(1);
					mem_wdata = mem_rdata;
					if (addr_s1 == tgt_q) begin
						state_d = S_PUT;
					end
				end
			end

			S_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = tgt_q;
				mem_wdata = val_q;
				cnt_d     = cnt_q + CW'(1);
				done_d    = 1'b1;
				state_d   = S_IDLE;
			end

			S_SHIFT_DN: begin
				if (iss_q) begin
					mem_re = 1'b1;
					vld_d  = 1'b1;
					addr_d = ptr_q;
					if (ptr_q == last_a) begin
						iss_d = 1'b0;
					end else begin
						ptr_d = ptr_q + AW'(1);
					end
				end
				if (vld_s1) begin
					mem_we    = 1'b1;
					mem_waddr = addr_s1 - AW'(1);
					mem_wdata = mem_rdata;
					if (addr_s1 == last_a) begin
						cnt_d   = cnt_m1;
						done_d  = 1'b1;
						state_d = S_IDLE;
					end
				end
			end

			S_SEARCH: begin
				if (iss_q) begin
					mem_re = 1'b1;
					vld_d  = 1'b1;
					addr_d = ptr_q;
					if (ptr_q == last_a) begin
						iss_d = 1'b0;
					end else begin
						ptr_d = ptr_q + AW'(1);
					end
				end
				if (vld_s1) begin
					if (mem_rdata == val_q) begin
						// First match: the read already in flight is dropped.
						vld_d = 1'b0;
						iss_d = 1'b0;
						if (cmd_q == CMD_INDEX_OF) begin
							done_d  = 1'b1;
							found_d = addr_ext[POS_W-1:0];
							state_d = S_IDLE;
						end else if (addr_s1 == last_a) begin
							cnt_d   = cnt_m1;
							done_d  = 1'b1;
							state_d = S_IDLE;
						end else begin
							ptr_d   = addr_s1 + AW'(1);
							iss_d   = 1'b1;
							state_d = S_SHIFT_DN;
						end
					end else if (addr_s1 == last_a) begin
						done_d   = 1'b1;
						status_d = ST_ABSENT;
						state_d  = S_IDLE;
					end
				end
			end

			S_READ: begin
				if (iss_q) begin
					mem_re = 1'b1;
					vld_d  = 1'b1;
					addr_d = ptr_q;
					iss_d  = 1'b0;
				end
				if (vld_s1) begin
					done_d  = 1'b1;
					read_d  = rd_ext[EXT_W-1:0];
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy           = (state_q != S_IDLE);
	assign done           = done_q;
	assign status         = status_q;
	assign read_value     = read_q;
	assign found_position = found_q;
	assign entry_count    = cnt_ext[COUNT_W-1:0];

	// A result is only shown once the sequencer is back at rest.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while a request is still in progress");

	// An accepted request is either finished at once or keeps the block busy.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted request neither finished nor in progress");

	// The count never passes the capacity of the store.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	// Read data in flight only exists during a memory walk.
	a_s1_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q != S_IDLE && state_q != S_PUT))
		else $error("stage one valid outside a walk");

	// A shift never reads and writes the same entry in one cycle.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("read and write of the same entry in one cycle");

endmodule
